### rtl/siu_pkg.sv
// Shared constants and register codes for the segment intersection unit.
// No dependencies.
package siu_pkg;

    localparam int COORD_WIDTH_DEF = 32;

    localparam int THR_W      = 32;
    localparam int TOL_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_DET_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_TOLERANCE = 1'd1;

    localparam logic [THR_W-1:0] DET_THRESHOLD_RST = 32'd5;
    localparam logic [TOL_W-1:0] SEG_TOLERANCE_RST = 16'd1;

endpackage

### rtl/seg_in_if.sv
// Input channel of the segment intersection unit: two segments per beat.
// No dependencies.
interface seg_in_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] a_x;
    logic signed [W-1:0] a_y;
    logic signed [W-1:0] b_x;
    logic signed [W-1:0] b_y;
    logic signed [W-1:0] c_x;
    logic signed [W-1:0] c_y;
    logic signed [W-1:0] d_x;
    logic signed [W-1:0] d_y;

    modport source (output valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, input ready);
    modport sink   (input valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, output ready);
endinterface

### rtl/seg_out_if.sv
// Output channel of the segment intersection unit: hit flag and point per beat.
// No dependencies.
interface seg_out_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic                hit;
    logic signed [W-1:0] cross_x;
    logic signed [W-1:0] cross_y;

    modport source (output valid, hit, cross_x, cross_y, input ready);
    modport sink   (input valid, hit, cross_x, cross_y, output ready);
endinterface

### rtl/siu_line.sv
// Line equation stages: edge deltas, exact products, c terms and determinant.
// Three register stages; no package dependencies.
module siu_line #(
    parameter int W  = 32,
    parameter int SW = 8 * W
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [SW-1:0]           side_in,
    output logic                    out_valid,
    output logic signed [W:0]       a1,
    output logic signed [W:0]       b1,
    output logic signed [W:0]       a2,
    output logic signed [W:0]       b2,
    output logic signed [2*W+1:0]   c1,
    output logic signed [2*W+1:0]   c2,
    output logic signed [2*W+2:0]   det,
    output logic [SW-1:0]           side_out
);
    localparam int DW   = W + 1;
    localparam int PW   = 2 * W + 1;
    localparam int CW   = 2 * W + 2;
    localparam int DETW = 2 * W + 3;

    logic signed [W-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    logic [2:0] v_reg;

    logic signed [DW-1:0] a1_1_reg, b1_1_reg, a2_1_reg, b2_1_reg;
    logic signed [DW-1:0] a1_2_reg, b1_2_reg, a2_2_reg, b2_2_reg;
    logic signed [DW-1:0] a1_3_reg, b1_3_reg, a2_3_reg, b2_3_reg;
    logic [SW-1:0] side_1_reg, side_2_reg, side_3_reg;
    logic signed [W-1:0] ax1, ay1, cx1, cy1;
    logic signed [PW-1:0] p1_next, p2_next, p3_next, p4_next;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [CW-1:0] p5_next, p6_next, p5_reg, p6_reg;
    logic signed [CW-1:0] c1_reg, c2_reg;
    logic signed [DETW-1:0] det_reg;

    assign ax = $signed(side_in[0*W +: W]);
    assign ay = $signed(side_in[1*W +: W]);
    assign bx = $signed(side_in[2*W +: W]);
    assign by = $signed(side_in[3*W +: W]);
    assign cx = $signed(side_in[4*W +: W]);
    assign cy = $signed(side_in[5*W +: W]);
    assign dx = $signed(side_in[6*W +: W]);
    assign dy = $signed(side_in[7*W +: W]);

    assign ax1 = $signed(side_1_reg[0*W +: W]);
    assign ay1 = $signed(side_1_reg[1*W +: W]);
    assign cx1 = $signed(side_1_reg[4*W +: W]);
    assign cy1 = $signed(side_1_reg[5*W +: W]);

    always_comb
    begin
        p1_next = PW'(a1_1_reg) * PW'(ax1);
        p2_next = PW'(b1_1_reg) * PW'(ay1);
        p3_next = PW'(a2_1_reg) * PW'(cx1);
        p4_next = PW'(b2_1_reg) * PW'(cy1);
        p5_next = CW'(a1_1_reg) * CW'(b2_1_reg);
        p6_next = CW'(a2_1_reg) * CW'(b1_1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_1_reg <= side_in;
            a1_1_reg   <= DW'(by) - DW'(ay);
            b1_1_reg   <= DW'(ax) - DW'(bx);
            a2_1_reg   <= DW'(dy) - DW'(cy);
            b2_1_reg   <= DW'(cx) - DW'(dx);

            side_2_reg <= side_1_reg;
            a1_2_reg   <= a1_1_reg;
            b1_2_reg   <= b1_1_reg;
            a2_2_reg   <= a2_1_reg;
            b2_2_reg   <= b2_1_reg;
            p1_reg     <= p1_next;
            p2_reg     <= p2_next;
            p3_reg     <= p3_next;
            p4_reg     <= p4_next;
            p5_reg     <= p5_next;
            p6_reg     <= p6_next;

            side_3_reg <= side_2_reg;
            a1_3_reg   <= a1_2_reg;
            b1_3_reg   <= b1_2_reg;
            a2_3_reg   <= a2_2_reg;
            b2_3_reg   <= b2_2_reg;
            c1_reg     <= CW'(p1_reg) + CW'(p2_reg);
            c2_reg     <= CW'(p3_reg) + CW'(p4_reg);
            det_reg    <= DETW'(p5_reg) - DETW'(p6_reg);
        end
    end

    assign out_valid = v_reg[2];
    assign a1        = a1_3_reg;
    assign b1        = b1_3_reg;
    assign a2        = a2_3_reg;
    assign b2        = b2_3_reg;
    assign c1        = c1_reg;
    assign c2        = c2_reg;
    assign det       = det_reg;
    assign side_out  = side_3_reg;
endmodule

### rtl/siu_num.sv
// Numerator stages: split wide products, numerators, magnitudes and parallel test.
// Four register stages; uses siu_pkg for the threshold width.
module siu_num #(
    parameter int W  = 32,
    parameter int SW = 8 * W
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [siu_pkg::THR_W-1:0]  det_threshold,
    input  logic signed [W:0]          a1,
    input  logic signed [W:0]          b1,
    input  logic signed [W:0]          a2,
    input  logic signed [W:0]          b2,
    input  logic signed [2*W+1:0]      c1,
    input  logic signed [2*W+1:0]      c2,
    input  logic signed [2*W+2:0]      det,
    input  logic [SW-1:0]              side_in,
    output logic                       out_valid,
    output logic [3*W+3:0]             x_mag,
    output logic [3*W+3:0]             y_mag,
    output logic                       x_neg,
    output logic                       y_neg,
    output logic [2*W+2:0]             den_mag,
    output logic                       miss,
    output logic [SW-1:0]              side_out
);
    import siu_pkg::*;

    localparam int DW   = W + 1;
    localparam int CW   = 2 * W + 2;
    localparam int DETW = 2 * W + 3;
    localparam int LW   = W + 2;
    localparam int PLW  = DW + LW;
    localparam int PHW  = DW + DW;
    localparam int MW   = 3 * W + 3;
    localparam int NW   = 3 * W + 4;

    logic [3:0] v_reg;

    logic signed [LW-1:0] c1_lo, c2_lo;
    logic signed [DW-1:0] c1_hi, c2_hi;

    logic signed [PLW-1:0] l1_reg, l2_reg, l3_reg, l4_reg;
    logic signed [PHW-1:0] h1_reg, h2_reg, h3_reg, h4_reg;
    logic signed [DETW-1:0] det_4_reg;
    logic [SW-1:0] side_4_reg, side_5_reg, side_6_reg, side_7_reg;

    logic signed [MW-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic [DETW-1:0] dmag_next, dmag_5_reg, dmag_6_reg, dmag_7_reg;
    logic dneg_5_reg, dneg_6_reg;
    logic miss_5_reg, miss_6_reg, miss_7_reg;

    logic signed [NW-1:0] nx_reg, ny_reg;
    logic [NW-1:0] xmag_reg, ymag_reg;
    logic xneg_reg, yneg_reg;

    assign c1_lo = $signed({1'b0, c1[W:0]});
    assign c2_lo = $signed({1'b0, c2[W:0]});
    assign c1_hi = c1[CW-1:W+1];
    assign c2_hi = c2[CW-1:W+1];

    assign dmag_next = det_4_reg[DETW-1] ? DETW'(-det_4_reg) : DETW'(det_4_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l1_reg     <= PLW'(b2) * PLW'(c1_lo);
            h1_reg     <= PHW'(b2) * PHW'(c1_hi);
            l2_reg     <= PLW'(b1) * PLW'(c2_lo);
            h2_reg     <= PHW'(b1) * PHW'(c2_hi);
            l3_reg     <= PLW'(a1) * PLW'(c2_lo);
            h3_reg     <= PHW'(a1) * PHW'(c2_hi);
            l4_reg     <= PLW'(a2) * PLW'(c1_lo);
            h4_reg     <= PHW'(a2) * PHW'(c1_hi);
            det_4_reg  <= det;
            side_4_reg <= side_in;

            m1_reg     <= (MW'(h1_reg) <<< (W + 1)) + MW'(l1_reg);
            m2_reg     <= (MW'(h2_reg) <<< (W + 1)) + MW'(l2_reg);
            m3_reg     <= (MW'(h3_reg) <<< (W + 1)) + MW'(l3_reg);
            m4_reg     <= (MW'(h4_reg) <<< (W + 1)) + MW'(l4_reg);
            dmag_5_reg <= dmag_next;
            dneg_5_reg <= det_4_reg[DETW-1];
            miss_5_reg <= (dmag_next == '0) || (dmag_next < DETW'(det_threshold));
            side_5_reg <= side_4_reg;

            nx_reg     <= NW'(m1_reg) - NW'(m2_reg);
            ny_reg     <= NW'(m3_reg) - NW'(m4_reg);
            dmag_6_reg <= dmag_5_reg;
            dneg_6_reg <= dneg_5_reg;
            miss_6_reg <= miss_5_reg;
            side_6_reg <= side_5_reg;

            xmag_reg   <= nx_reg[NW-1] ? NW'(-nx_reg) : NW'(nx_reg);
            ymag_reg   <= ny_reg[NW-1] ? NW'(-ny_reg) : NW'(ny_reg);
            xneg_reg   <= nx_reg[NW-1] ^ dneg_6_reg;
            yneg_reg   <= ny_reg[NW-1] ^ dneg_6_reg;
            dmag_7_reg <= dmag_6_reg;
            miss_7_reg <= miss_6_reg;
            side_7_reg <= side_6_reg;
        end
    end

    assign out_valid = v_reg[3];
    assign x_mag     = xmag_reg;
    assign y_mag     = ymag_reg;
    assign x_neg     = xneg_reg;
    assign y_neg     = yneg_reg;
    assign den_mag   = dmag_7_reg;
    assign miss      = miss_7_reg;
    assign side_out  = side_7_reg;
endmodule

### rtl/siu_div.sv
// Pipelined restoring divider, one quotient bit per stage, with clamp and sign.
// W + 2 register stages; no package dependencies.
module siu_div #(
    parameter int W  = 32,
    parameter int SW = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [3*W+3:0]       num_mag,
    input  logic                 neg,
    input  logic [2*W+2:0]       den_mag,
    input  logic [SW-1:0]        side_in,
    output logic                 out_valid,
    output logic signed [W-1:0]  quot,
    output logic [SW-1:0]        side_out
);
    localparam int NW   = 3 * W + 4;
    localparam int DETW = 2 * W + 3;
    localparam int NS   = W + 1;

    logic [NS-1:0]   v_reg;
    logic [NW-1:0]   rem_reg  [0:NS-1];
    logic [W:0]      q_reg    [0:NS-1];
    logic [DETW-1:0] den_reg  [0:NS-1];
    logic            neg_reg  [0:NS-1];
    logic [SW-1:0]   side_reg [0:NS-1];

    logic            vo_reg;
    logic [W-1:0]    quot_reg;
    logic [SW-1:0]   side_o_reg;
    logic [W:0]      lim;
    logic [W:0]      qc;
    logic [W:0]      qlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg  <= {v_reg[NS-2:0], in_valid};
            vo_reg <= v_reg[NS-1];
        end
    end

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        localparam int K = W - s;
        logic [NW-1:0]   rem_in;
        logic [W:0]      q_in;
        logic [DETW-1:0] den_in;
        logic            neg_in;
        logic [SW-1:0]   side_in_s;
        logic [NW-1:0]   shifted;
        logic            ge;

        if (s == 0)
        begin : g_first
            assign rem_in    = num_mag;
            assign q_in      = '0;
            assign den_in    = den_mag;
            assign neg_in    = neg;
            assign side_in_s = side_in;
        end
        else
        begin : g_rest
            assign rem_in    = rem_reg[s-1];
            assign q_in      = q_reg[s-1];
            assign den_in    = den_reg[s-1];
            assign neg_in    = neg_reg[s-1];
            assign side_in_s = side_reg[s-1];
        end

        assign shifted = NW'(den_in) << K;
        assign ge      = rem_in >= shifted;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= ge ? rem_in - shifted : rem_in;
                q_reg[s]    <= q_in | ((W+1)'(ge) << K);
                den_reg[s]  <= den_in;
                neg_reg[s]  <= neg_in;
                side_reg[s] <= side_in_s;
            end
        end
    end

    assign qlast = q_reg[NS-1];
    assign lim   = neg_reg[NS-1] ? ((W+1)'(1) << (W - 1)) : (((W+1)'(1) << (W - 1)) - 1'b1);
    assign qc    = (qlast > lim) ? lim : qlast;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg   <= neg_reg[NS-1] ? W'(-qc) : W'(qc);
            side_o_reg <= side_reg[NS-1];
        end
    end

    assign out_valid = vo_reg;
    assign quot      = $signed(quot_reg);
    assign side_out  = side_o_reg;
endmodule

### rtl/segment_intersection_unit.sv
// Segment intersection unit: Cramer solve of two segments with box test.
// Depends on siu_pkg, seg_in_if, seg_out_if, siu_line, siu_num and siu_div.
//
// Usage:
//   seg_in carries the endpoints A, B, C, D of two segments per beat; seg_out
//   returns hit and the intersection point per beat, in order, one result for
//   every input beat. Missed pairs return zero coordinates.
//   cfg_we/cfg_idx/cfg_data write det_threshold (index 0) and seg_tolerance
//   (index 1); write them only while no beat is in flight.
//   The pipeline is made of three line stages, four numerator stages,
//   COORD_WIDTH + 2 divider stages (one quotient bit per stage) and the output
//   register. Throughput is one beat per cycle while seg_out is not stalled.
//   All stages advance together; when seg_out is stalled with a result held,
//   the whole pipeline holds and seg_in.ready drops, so nothing is lost.
//   Reset clears all valid bits and loads det_threshold = 5, seg_tolerance = 1.
module segment_intersection_unit #(
    parameter int COORD_WIDTH = siu_pkg::COORD_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [siu_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [siu_pkg::CFG_DATA_W-1:0]  cfg_data,
    seg_in_if.sink                          seg_in,
    seg_out_if.source                       seg_out
);
    import siu_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int SW   = 8 * W;
    localparam int BW   = W + 2;

    logic [THR_W-1:0] det_threshold_reg;
    logic [TOL_W-1:0] seg_tolerance_reg;

    logic advance;
    logic [SW-1:0] side_in;

    logic                 l_valid;
    logic signed [W:0]    a1, b1, a2, b2;
    logic signed [2*W+1:0] c1, c2;
    logic signed [2*W+2:0] det;
    logic [SW-1:0]        l_side;

    logic                 n_valid;
    logic [3*W+3:0]       x_mag, y_mag;
    logic                 x_neg, y_neg;
    logic [2*W+2:0]       den_mag;
    logic                 miss;
    logic [SW-1:0]        n_side;

    logic                 vx, vy;
    logic signed [W-1:0]  px, py;
    logic [SW-1:0]        q_side;
    logic                 q_miss;

    logic signed [BW-1:0] tol;
    logic signed [BW-1:0] s_ax, s_ay, s_bx, s_by, s_cx, s_cy, s_dx, s_dy;
    logic signed [BW-1:0] bpx, bpy;
    logic                 in_ab, in_cd, hit_next;

    logic                 out_valid_reg;
    logic                 hit_reg;
    logic signed [W-1:0]  cross_x_reg, cross_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_threshold_reg <= DET_THRESHOLD_RST;
            seg_tolerance_reg <= SEG_TOLERANCE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_DET_THRESHOLD: det_threshold_reg <= cfg_data[THR_W-1:0];
                REG_SEG_TOLERANCE: seg_tolerance_reg <= cfg_data[TOL_W-1:0];
                default:           ;
            endcase
        end
    end

    assign advance      = !out_valid_reg || seg_out.ready;
    assign seg_in.ready = advance;
    assign side_in      = {seg_in.d_y, seg_in.d_x, seg_in.c_y, seg_in.c_x,
                           seg_in.b_y, seg_in.b_x, seg_in.a_y, seg_in.a_x};

    siu_line #(.W(W), .SW(SW)) u_line (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_valid (seg_in.valid),
        .side_in  (side_in),
        .out_valid(l_valid),
        .a1       (a1),
        .b1       (b1),
        .a2       (a2),
        .b2       (b2),
        .c1       (c1),
        .c2       (c2),
        .det      (det),
        .side_out (l_side)
    );

    siu_num #(.W(W), .SW(SW)) u_num (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (advance),
        .in_valid     (l_valid),
        .det_threshold(det_threshold_reg),
        .a1           (a1),
        .b1           (b1),
        .a2           (a2),
        .b2           (b2),
        .c1           (c1),
        .c2           (c2),
        .det          (det),
        .side_in      (l_side),
        .out_valid    (n_valid),
        .x_mag        (x_mag),
        .y_mag        (y_mag),
        .x_neg        (x_neg),
        .y_neg        (y_neg),
        .den_mag      (den_mag),
        .miss         (miss),
        .side_out     (n_side)
    );

    siu_div #(.W(W), .SW(SW)) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_valid (n_valid),
        .num_mag  (x_mag),
        .neg      (x_neg),
        .den_mag  (den_mag),
        .side_in  (n_side),
        .out_valid(vx),
        .quot     (px),
        .side_out (q_side)
    );

    siu_div #(.W(W), .SW(1)) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_valid (n_valid),
        .num_mag  (y_mag),
        .neg      (y_neg),
        .den_mag  (den_mag),
        .side_in  (miss),
        .out_valid(vy),
        .quot     (py),
        .side_out (q_miss)
    );

    assign tol  = $signed({{(BW-TOL_W){1'b0}}, seg_tolerance_reg});
    assign s_ax = BW'($signed(q_side[0*W +: W]));
    assign s_ay = BW'($signed(q_side[1*W +: W]));
    assign s_bx = BW'($signed(q_side[2*W +: W]));
    assign s_by = BW'($signed(q_side[3*W +: W]));
    assign s_cx = BW'($signed(q_side[4*W +: W]));
    assign s_cy = BW'($signed(q_side[5*W +: W]));
    assign s_dx = BW'($signed(q_side[6*W +: W]));
    assign s_dy = BW'($signed(q_side[7*W +: W]));
    assign bpx  = BW'(px);
    assign bpy  = BW'(py);

    always_comb
    begin
        in_ab = (bpx >= ((s_ax < s_bx) ? s_ax : s_bx) - tol)
             && (bpx <= ((s_ax > s_bx) ? s_ax : s_bx) + tol)
             && (bpy >= ((s_ay < s_by) ? s_ay : s_by) - tol)
             && (bpy <= ((s_ay > s_by) ? s_ay : s_by) + tol);
        in_cd = (bpx >= ((s_cx < s_dx) ? s_cx : s_dx) - tol)
             && (bpx <= ((s_cx > s_dx) ? s_cx : s_dx) + tol)
             && (bpy >= ((s_cy < s_dy) ? s_cy : s_dy) - tol)
             && (bpy <= ((s_cy > s_dy) ? s_cy : s_dy) + tol);
        hit_next = !q_miss && in_ab && in_cd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= vx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hit_reg     <= hit_next;
            cross_x_reg <= hit_next ? px : '0;
            cross_y_reg <= hit_next ? py : '0;
        end
    end

    assign seg_out.valid   = out_valid_reg;
    assign seg_out.hit     = hit_reg;
    assign seg_out.cross_x = cross_x_reg;
    assign seg_out.cross_y = cross_y_reg;

    a_div_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        vx == vy)
        else $error("divider lanes out of step");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        seg_out.valid && !seg_out.hit |-> seg_out.cross_x == '0 && seg_out.cross_y == '0)
        else $error("miss with nonzero point");

    a_parallel_miss: assert property (@(posedge clk) disable iff (!rst_n)
        advance && vx && q_miss |=> seg_out.valid && !seg_out.hit)
        else $error("parallel pair reported as hit");

    a_stall_only_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !seg_in.ready |-> seg_out.valid && !seg_out.ready)
        else $error("input stalled without output back-pressure");
endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for segment_intersection_unit: random and directed segment pairs
// with a bit-exact intersection predictor, random idling on both channels and a long stall.
// Depends on siu_pkg, seg_in_if, seg_out_if and the RTL of the unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import siu_pkg::*;

    localparam int W = COORD_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic signed [W-1:0] coord_t;
    typedef logic signed [127:0] wide_t;

    typedef struct {
        coord_t a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y;
    } seg_pair_t;

    typedef struct {
        logic   hit;
        coord_t x;
        coord_t y;
    } crossing_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    seg_in_if  #(.W(W)) seg_in ();
    seg_out_if #(.W(W)) seg_out ();

    segment_intersection_unit #(.COORD_WIDTH(W)) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .cfg_idx (cfg_idx),
        .cfg_data(cfg_data),
        .seg_in  (seg_in.sink),
        .seg_out (seg_out.source)
    );

    seg_pair_t   pending_pairs[$];
    crossing_t   expected_crossings[$];
    logic [31:0] det_thr = DET_THRESHOLD_RST;
    logic [15:0] box_tol = SEG_TOLERANCE_RST;
    bit          idle_on = 1'b1;
    int          in_gap = 0;
    int          out_stall = 0;
    int          hold_cycles = 0;
    bit          in_beat = 1'b0;
    bit          out_beat = 1'b0;
    int          errors = 0;
    int          cycles = 0;

    initial
    begin
        seg_in.valid = 1'b0;
        seg_in.a_x = '0; seg_in.a_y = '0; seg_in.b_x = '0; seg_in.b_y = '0;
        seg_in.c_x = '0; seg_in.c_y = '0; seg_in.d_x = '0; seg_in.d_y = '0;
        seg_out.ready = 1'b0;
    end

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic coord_t quotient_sat(wide_t num, wide_t den);
        logic        neg;
        logic [127:0] un, ud, q, lim;
        coord_t      m;
        neg = num[127] ^ den[127];
        un = num[127] ? -num : num;
        ud = den[127] ? -den : den;
        q = un / ud;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (q > lim)
            q = lim;
        m = q[W-1:0];
        return neg ? -m : m;
    endfunction

    function automatic bit within_box(longint px, longint py, coord_t sx, coord_t sy,
                                      coord_t ex, coord_t ey, longint tol);
        longint lox, hix, loy, hiy;
        lox = ((sx < ex) ? longint'(sx) : longint'(ex)) - tol;
        hix = ((sx > ex) ? longint'(sx) : longint'(ex)) + tol;
        loy = ((sy < ey) ? longint'(sy) : longint'(ey)) - tol;
        hiy = ((sy > ey) ? longint'(sy) : longint'(ey)) + tol;
        return px >= lox && px <= hix && py >= loy && py <= hiy;
    endfunction

    function automatic crossing_t solve_pair(seg_pair_t s);
        wide_t     a1, b1, a2, b2, c1, c2, det, mag, ax, ay, bx, by, cx, cy, dx, dy;
        coord_t    px, py;
        longint    tol;
        crossing_t r;
        ax = s.a_x; ay = s.a_y; bx = s.b_x; by = s.b_y;
        cx = s.c_x; cy = s.c_y; dx = s.d_x; dy = s.d_y;
        a1 = by - ay; b1 = ax - bx;
        a2 = dy - cy; b2 = cx - dx;
        c1 = a1 * ax + b1 * ay;
        c2 = a2 * cx + b2 * cy;
        det = a1 * b2 - a2 * b1;
        mag = det[127] ? -det : det;
        tol = longint'(box_tol);
        r = '{1'b0, '0, '0};
        if (det == 0 || mag < wide_t'({96'd0, det_thr}))
            return r;
        px = quotient_sat(b2 * c1 - b1 * c2, det);
        py = quotient_sat(a1 * c2 - a2 * c1, det);
        if (within_box(px, py, s.a_x, s.a_y, s.b_x, s.b_y, tol) &&
            within_box(px, py, s.c_x, s.c_y, s.d_x, s.d_y, tol))
            r = '{1'b1, px, py};
        return r;
    endfunction

    function automatic coord_t rand_span(int bits);
        coord_t v;
        v = $urandom;
        return v >>> (W - bits);
    endfunction

    function automatic seg_pair_t random_pair();
        seg_pair_t s;
        coord_t    px, py, ux, uy, vx, vy;
        int        kind;
        kind = $urandom_range(0, 9);
        px = rand_span(26); py = rand_span(26);
        ux = rand_span(22); uy = rand_span(22);
        vx = rand_span(22); vy = rand_span(22);
        if (kind < 5)
        begin
            s = '{px - ux, py - uy, px + ux, py + uy, px - vx, py - vy, px + vx, py + vy};
            if (kind == 4)
                s.d_x = s.d_x + rand_span(4);
        end
        else if (kind == 5)
        begin
            s = '{px, py, px + ux, py + uy, px + vx, py + vy,
                  px + vx + 2 * ux, py + vy + 2 * uy};
        end
        else if (kind == 6)
        begin
            s = '{px, py, px + ux, py + uy, px + ux + rand_span(2), py + uy, px + vx, py + vy};
        end
        else if (kind == 7)
        begin
            s = '{rand_span(24), rand_span(24), rand_span(24), rand_span(24),
                  rand_span(24), rand_span(24), rand_span(24), rand_span(24)};
        end
        else
        begin
            s = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end
        return s;
    endfunction

    function automatic void add_pair(seg_pair_t s);
        pending_pairs = {pending_pairs, s};
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        if (idx == REG_DET_THRESHOLD)
            det_thr = val;
        else
            box_tol = val[15:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_pairs.size() != 0 || seg_in.valid || expected_crossings.size() != 0);
    endtask

    task automatic push_random(int n);
        repeat (n) add_pair(random_pair());
    endtask

    localparam coord_t ONE = 32'sh0001_0000;
    localparam coord_t CMIN = 32'sh8000_0000;
    localparam coord_t CMAX = 32'sh7fff_ffff;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (seg_in.valid && !in_beat)
            begin
            end
            else if (in_gap > 0)
            begin
                in_gap--;
                seg_in.valid <= 1'b0;
            end
            else if (pending_pairs.size() > 0)
            begin
                seg_pair_t s;
                s = pending_pairs.pop_front();
                seg_in.a_x <= s.a_x; seg_in.a_y <= s.a_y;
                seg_in.b_x <= s.b_x; seg_in.b_y <= s.b_y;
                seg_in.c_x <= s.c_x; seg_in.c_y <= s.c_y;
                seg_in.d_x <= s.d_x; seg_in.d_y <= s.d_y;
                seg_in.valid <= 1'b1;
                in_gap = idle_on ? $urandom_range(0, 4) : 0;
            end
            else
            begin
                seg_in.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_beat)
                out_stall = idle_on ? $urandom_range(0, 4) : 0;
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                seg_out.ready <= 1'b0;
            end
            else if (out_stall > 0)
            begin
                out_stall--;
                seg_out.ready <= 1'b0;
            end
            else
            begin
                seg_out.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycles++;
            in_beat <= seg_in.valid && seg_in.ready;
            out_beat <= seg_out.valid && seg_out.ready;
            if (seg_in.valid && seg_in.ready)
                expected_crossings = {expected_crossings, solve_pair('{seg_in.a_x, seg_in.a_y,
                    seg_in.b_x, seg_in.b_y, seg_in.c_x, seg_in.c_y, seg_in.d_x, seg_in.d_y})};
            if (seg_out.valid && seg_out.ready)
            begin
                if (expected_crossings.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected beat hit=%0b x=%0d y=%0d", $time,
                             seg_out.hit, seg_out.cross_x, seg_out.cross_y);
                end
                else
                begin
                    crossing_t e;
                    e = expected_crossings.pop_front();
                    if (seg_out.hit !== e.hit || seg_out.cross_x !== e.x ||
                        seg_out.cross_y !== e.y)
                    begin
                        errors++;
                        $display("%0t: expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                                 $time, e.hit, e.x, e.y, seg_out.hit, seg_out.cross_x,
                                 seg_out.cross_y);
                    end
                end
            end
            if (cycles > CYCLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        add_pair('{-ONE, 0, ONE, 0, 0, -ONE, 0, ONE});
        add_pair('{0, 0, ONE, ONE, 0, ONE, ONE, 2 * ONE});
        add_pair('{0, 0, 2 * ONE, 0, ONE, 0, 3 * ONE, 0});
        add_pair('{0, 0, 0, 0, 0, 0, 0, 0});
        add_pair('{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN});
        add_pair('{CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX});
        add_pair('{0, 0, 32'sh4000_0000, 1, 0, 1, 32'sh4000_0000, 3});
        add_pair('{CMIN, 0, CMIN + 2, 1, CMIN, 1, CMIN + 2, 3});
        add_pair('{CMAX - 2, 0, CMAX, 1, CMAX - 2, 1, CMAX, 3});
        add_pair('{0, 0, 2 * ONE, 0, ONE, 0, ONE, ONE});
        add_pair('{0, 0, 2 * ONE, 0, ONE, 1, ONE, ONE});
        add_pair('{0, 0, 2 * ONE, 0, ONE, 2, ONE, ONE});
        add_pair('{0, 0, ONE, 0, ONE + 1, -ONE, ONE + 1, ONE});
        add_pair('{0, 0, ONE, 0, ONE + 2, -ONE, ONE + 2, ONE});
        add_pair('{0, 0, 3, 0, 0, 0, 0, 2});
        add_pair('{0, 0, 1, 1, 0, 1, 1, 0});
        add_pair('{-1, -1, -1, -1, CMAX, CMAX, CMAX, CMAX});
        push_random(140);
        wait_drained();

        write_reg(REG_DET_THRESHOLD, 32'd0);
        write_reg(REG_SEG_TOLERANCE, 32'hffff_0000);
        add_pair('{0, 0, 0, 0, 0, 0, 0, 0});
        add_pair('{0, 0, ONE, ONE, 2 * ONE, 2 * ONE, 3 * ONE, 3 * ONE});
        add_pair('{0, 0, 1, 1, 0, 1, 1, 0});
        push_random(150);
        @(posedge clk);
        hold_cycles = 300;
        wait_drained();

        write_reg(REG_DET_THRESHOLD, 32'hffff_ffff);
        write_reg(REG_SEG_TOLERANCE, 32'habcd_ffff);
        idle_on = 1'b0;
        add_pair('{0, 0, 1, 1, 0, 1, 1, 0});
        add_pair('{0, 0, 2 * ONE, 0, ONE, 1, ONE, ONE});
        push_random(150);
        wait_drained();
        idle_on = 1'b1;

        repeat (3)
        begin
            write_reg(REG_DET_THRESHOLD,
                      $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 64));
            write_reg(REG_SEG_TOLERANCE, $urandom);
            idle_on = $urandom_range(0, 3) != 0;
            push_random(130);
            wait_drained();
        end

        repeat (60) @(posedge clk);
        if (errors == 0 && expected_crossings.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
